>>> hw/rtl/face_dof_numbering_table_defines.svh
// assertion macros for the face numbering table checker
`ifndef FACE_DOF_NUMBERING_TABLE_DEFINES_SVH
`define FACE_DOF_NUMBERING_TABLE_DEFINES_SVH
// implication checked on every rising clock edge outside reset
`define FDN_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// next-cycle implication checked outside reset
`define FDN_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

>>> hw/rtl/fdn_pkg.sv
// shared types and constants for the face numbering table
`timescale 1ns / 1ps
package fdn_pkg;
   localparam int MaxFaces = 1024;
   localparam int NodeBits = 24;
   localparam int IdBits   = $clog2(MaxFaces);
   localparam int CntBits  = IdBits + 1;

   typedef enum logic [2:0] {
      ST_FOUND    = 3'd0,
      ST_INSERTED = 3'd1,
      ST_ABSENT   = 3'd2,
      ST_FULL     = 3'd3,
      ST_BAD      = 3'd4,
      ST_RANGE    = 3'd5
   } status_type;

   localparam logic REQ_INSERT = 1'b0;
   localparam logic REQ_QUERY  = 1'b1;

   // classified item passed from front to back
   typedef struct packed {
      logic                is_query;
      logic                bad;
      logic                range_err;
      logic [NodeBits-1:0] k0;
      logic [NodeBits-1:0] k1;
      logic [NodeBits-1:0] k2;
      logic [NodeBits-1:0] k3;
      logic [NodeBits-1:0] q0;
      logic [NodeBits-1:0] q1;
      logic [3:0]          ix;
      logic [3:0]          iy;
   } item_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_SCAN,
      BK_WAIT,
      BK_CALC,
      BK_MUL,
      BK_OUT
   } back_state_type;
endpackage

>>> hw/rtl/fdn_front.sv
// front end: canonical key, range check, one-entry output register
`timescale 1ns / 1ps
module fdn_front import fdn_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_type,
   input  logic [NodeBits-1:0] corner_a,
   input  logic [NodeBits-1:0] corner_b,
   input  logic [NodeBits-1:0] corner_c,
   input  logic [NodeBits-1:0] corner_d,
   input  logic [3:0]          local_x,
   input  logic [3:0]          local_y,
   input  logic [4:0]          order_m,
   output logic                item_valid,
   input  logic                item_ready,
   output item_type            item
);
   logic     valid_ff, valid_in;
   item_type item_ff, item_in;
   logic [NodeBits-1:0] k1, k2;
   logic [4:0] n;

   assign req_ready  = !valid_ff || item_ready;
   assign item_valid = valid_ff;
   assign item       = item_ff;
   assign n = order_m - 5'd2;

   // rotate smallest corner first, then order second and third
   always_comb begin
      item_in = '0;
      item_in.is_query = (req_type == REQ_QUERY);
      item_in.q0 = corner_a;
      item_in.q1 = corner_b;
      item_in.ix = local_x;
      item_in.iy = local_y;
      k1 = '0;
      k2 = '0;
      if (corner_a < corner_b && corner_a < corner_c && corner_a < corner_d) begin
         item_in.k0 = corner_a; k1 = corner_b; k2 = corner_c; item_in.k3 = corner_d;
      end else if (corner_b < corner_a && corner_b < corner_c && corner_b < corner_d) begin
         item_in.k0 = corner_b; k1 = corner_d; k2 = corner_a; item_in.k3 = corner_c;
      end else if (corner_c < corner_a && corner_c < corner_b && corner_c < corner_d) begin
         item_in.k0 = corner_c; k1 = corner_a; k2 = corner_d; item_in.k3 = corner_b;
      end else if (corner_d < corner_a && corner_d < corner_b && corner_d < corner_c) begin
         item_in.k0 = corner_d; k1 = corner_c; k2 = corner_b; item_in.k3 = corner_a;
      end else begin
         item_in.bad = 1'b1;
      end
      if (k2 < k1) begin
         item_in.k1 = k2; item_in.k2 = k1;
      end else begin
         item_in.k1 = k1; item_in.k2 = k2;
      end
      item_in.range_err = (order_m < 5'd2) || (order_m > 5'd16) ||
                          ({1'b0, local_x} >= n) || ({1'b0, local_y} >= n);
   end

   // handoff register
   always_comb begin
      valid_in = valid_ff;
      if (req_valid && req_ready) valid_in = 1'b1;
      else if (item_ready) valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else valid_ff <= valid_in;
      if (req_valid && req_ready) item_ff <= item_in;
   end
endmodule

>>> hw/rtl/fdn_back.sv
// back end: sequential key search, insert, dof arithmetic
`timescale 1ns / 1ps
module fdn_back import fdn_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              item_valid,
   output logic              item_ready,
   input  item_type          item,
   input  logic [4:0]        order_m,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [9:0]        rsp_face_number,
   output logic [17:0]       rsp_dof_index,
   output logic signed [3:0] rsp_orient_code,
   output logic [2:0]        rsp_status
);
   logic [4*NodeBits-1:0] keys [MaxFaces];
   logic [4*NodeBits-1:0] rd_ff;
   back_state_type state_ff, state_in;
   item_type       cur_ff;
   logic [CntBits-1:0] count_ff, idx_ff;
   logic [IdBits-1:0]  id_ff;
   logic [4:0]  n_ff;
   logic signed [3:0] orient_ff, orient_c;
   logic [9:0]  nn_ff;
   logic [8:0]  off_ff;
   logic [9:0]  fn_ff;
   logic [17:0] dof_ff;
   logic [2:0]  st_ff;
   logic        match, hit, last, start, imm;
   logic [3:0]  r, ax, ay;
   logic [4*NodeBits-1:0] key;

   assign key   = {cur_ff.k3, cur_ff.k2, cur_ff.k1, cur_ff.k0};
   assign match = (rd_ff == key);
   // entry idx_ff-1 is under the read data; only stored entries count
   assign hit   = match && (count_ff != '0);
   assign last  = (idx_ff >= count_ff);
   assign item_ready = (state_ff == BK_IDLE);
   assign start = item_valid && item_ready;
   assign imm   = item.bad || (item.is_query && item.range_err);
   assign rsp_valid = (state_ff == BK_OUT);
   assign rsp_face_number = fn_ff;
   assign rsp_dof_index   = dof_ff;
   assign rsp_orient_code = orient_ff;
   assign rsp_status      = st_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: if (start) state_in = imm ? BK_OUT : BK_WAIT;
         BK_WAIT: state_in = BK_SCAN;
         BK_SCAN: begin
            if (hit) state_in = cur_ff.is_query ? BK_CALC : BK_OUT;
            else if (last) state_in = BK_OUT;
         end
         BK_CALC: state_in = BK_MUL;
         BK_MUL:  state_in = BK_OUT;
         BK_OUT:  if (rsp_ready) state_in = BK_IDLE;
         default: state_in = BK_IDLE;
      endcase
   end

   // orientation from given first two corners
   always_comb begin
      orient_c = 4'sd0;
      if      (cur_ff.k0 == cur_ff.q0 && cur_ff.k1 == cur_ff.q1) orient_c = 4'sd1;
      else if (cur_ff.k0 == cur_ff.q0 && cur_ff.k2 == cur_ff.q1) orient_c = -4'sd1;
      else if (cur_ff.k1 == cur_ff.q0 && cur_ff.k3 == cur_ff.q1) orient_c = 4'sd2;
      else if (cur_ff.k1 == cur_ff.q0 && cur_ff.k0 == cur_ff.q1) orient_c = -4'sd2;
      else if (cur_ff.k3 == cur_ff.q0 && cur_ff.k2 == cur_ff.q1) orient_c = 4'sd3;
      else if (cur_ff.k3 == cur_ff.q0 && cur_ff.k1 == cur_ff.q1) orient_c = -4'sd3;
      else if (cur_ff.k2 == cur_ff.q0 && cur_ff.k0 == cur_ff.q1) orient_c = 4'sd4;
      else if (cur_ff.k2 == cur_ff.q0 && cur_ff.k3 == cur_ff.q1) orient_c = -4'sd4;
      r = n_ff[3:0] - 4'd1;
      ax = cur_ff.ix;
      ay = cur_ff.iy;
      case (orient_c)
         4'sd1:   begin ax = cur_ff.iy;       ay = cur_ff.ix; end
         4'sd2:   begin ax = r - cur_ff.ix;   ay = cur_ff.iy; end
         4'sd3:   begin ax = r - cur_ff.iy;   ay = r - cur_ff.ix; end
         4'sd4:   begin ax = cur_ff.ix;       ay = r - cur_ff.iy; end
         -4'sd1:  begin ax = cur_ff.ix;       ay = cur_ff.iy; end
         -4'sd2:  begin ax = cur_ff.iy;       ay = r - cur_ff.ix; end
         -4'sd3:  begin ax = r - cur_ff.ix;   ay = r - cur_ff.iy; end
         -4'sd4:  begin ax = r - cur_ff.iy;   ay = cur_ff.ix; end
         default: begin ax = 4'd0;            ay = 4'd0; end
      endcase
   end

   // key store, read data registered
   always_ff @(posedge clock) begin
      rd_ff <= keys[idx_ff[IdBits-1:0]];
      if (state_ff == BK_SCAN && last && !hit && !cur_ff.is_query &&
          count_ff < CntBits'(MaxFaces))
         keys[count_ff[IdBits-1:0]] <= key;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == BK_SCAN && last && !hit &&
             !cur_ff.is_query && count_ff < CntBits'(MaxFaces))
            count_ff <= count_ff + 1'b1;
      end
   end

   // datapath: idx_ff leads the registered read by one entry
   always_ff @(posedge clock) begin
      unique case (state_ff)
         BK_IDLE: begin
            cur_ff <= item;
            idx_ff <= '0;
            n_ff   <= order_m - 5'd2;
            orient_ff <= 4'sd0;
            fn_ff  <= '0;
            dof_ff <= '0;
            st_ff  <= item.bad ? ST_BAD : ST_RANGE;
         end
         BK_WAIT: idx_ff <= idx_ff + 1'b1;
         BK_SCAN: begin
            id_ff <= IdBits'(idx_ff - 1'b1);
            if (hit) begin
               st_ff <= ST_FOUND;
               if (!cur_ff.is_query) fn_ff <= 10'(idx_ff - 1'b1);
            end else if (last) begin
               if (cur_ff.is_query) st_ff <= ST_ABSENT;
               else if (count_ff >= CntBits'(MaxFaces)) st_ff <= ST_FULL;
               else begin
                  st_ff <= ST_INSERTED;
                  fn_ff <= 10'(count_ff);
               end
            end
            idx_ff <= idx_ff + 1'b1;
         end
         BK_CALC: begin
            orient_ff <= orient_c;
            nn_ff   <= {5'd0, n_ff} * {5'd0, n_ff};
            off_ff  <= ({5'd0, ax} * {4'd0, n_ff}) + {5'd0, ay};
            if (orient_c == 4'sd0) st_ff <= ST_BAD;
         end
         BK_MUL: begin
            if (orient_ff != 4'sd0) begin
               fn_ff  <= 10'(id_ff);
               dof_ff <= ({8'd0, id_ff} * {8'd0, nn_ff}) + {9'd0, off_ff};
            end
         end
         default: ;
      endcase
   end
endmodule

>>> hw/rtl/face_dof_numbering_table.sv
// Face numbering table top level.
// Bad corners, and out-of-range indices on queries, go from idle straight to the result;
// inserts and absent queries wait for the first key read and then scan the stored keys;
// found queries add the orientation and multiply steps before the result.
// Throughput: one item in the back end at a time, set by the one-entry-per-cycle key search.
// Reset: synchronous active high; empties the table and sets order_m to 3.
`timescale 1ns / 1ps
module face_dof_numbering_table import fdn_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_type,
   input  logic [23:0]       req_corner_a,
   input  logic [23:0]       req_corner_b,
   input  logic [23:0]       req_corner_c,
   input  logic [23:0]       req_corner_d,
   input  logic [3:0]        req_local_x,
   input  logic [3:0]        req_local_y,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [9:0]        rsp_face_number,
   output logic [17:0]       rsp_dof_index,
   output logic signed [3:0] rsp_orient_code,
   output logic [2:0]        rsp_status,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [1:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);
   logic [4:0] order_ff;
   logic       item_valid, item_ready;
   item_type   item;

   assign pready = 1'b1;
   assign prdata = (paddr == 2'd0) ? {27'd0, order_ff} : 32'd0;

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) order_ff <= 5'd3;
      else if (psel && penable && pwrite && paddr == 2'd0) order_ff <= pwdata[4:0];
   end

   fdn_front u_front (
      .clock, .reset, .req_valid, .req_ready, .req_type,
      .corner_a(req_corner_a[NodeBits-1:0]), .corner_b(req_corner_b[NodeBits-1:0]),
      .corner_c(req_corner_c[NodeBits-1:0]), .corner_d(req_corner_d[NodeBits-1:0]),
      .local_x(req_local_x), .local_y(req_local_y), .order_m(order_ff),
      .item_valid, .item_ready, .item
   );

   fdn_back u_back (
      .clock, .reset, .item_valid, .item_ready, .item, .order_m(order_ff),
      .rsp_valid, .rsp_ready, .rsp_face_number, .rsp_dof_index,
      .rsp_orient_code, .rsp_status
   );
endmodule

>>> hw/rtl/fdn_checker.sv
// port-level checker for the face numbering table
`timescale 1ns / 1ps
`include "face_dof_numbering_table_defines.svh"
module fdn_checker import fdn_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [17:0]       rsp_dof_index,
   input logic signed [3:0] rsp_orient_code,
   input logic [2:0]        rsp_status,
   input logic              pready
);
   `FDN_ASSERT_IMP(a_dof_ok, clock, reset, rsp_valid && rsp_status != ST_FOUND, rsp_dof_index == 18'd0, "dof set on failure")
   `FDN_ASSERT_IMP(a_orient_ok, clock, reset, rsp_valid && rsp_status != ST_FOUND, rsp_orient_code == 4'sd0, "orient set on failure")
   `FDN_ASSERT_NEXT(a_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status), "result dropped")
   `FDN_ASSERT_IMP(a_ready, clock, reset, 1'b1, pready, "pready low")
endmodule

bind face_dof_numbering_table fdn_checker u_fdn_checker (
   .clock, .reset, .rsp_valid, .rsp_ready, .rsp_dof_index,
   .rsp_orient_code, .rsp_status, .pready
);

>>> verif/face_dof_numbering_table_test.sv
// testbench for the face numbering table: directed and random faces checked against a predictor
`timescale 1ns / 1ps
module face_dof_numbering_table_test;
   import fdn_pkg::*;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic              req_type = 1'b0;
   logic [23:0]       req_corner_a = '0;
   logic [23:0]       req_corner_b = '0;
   logic [23:0]       req_corner_c = '0;
   logic [23:0]       req_corner_d = '0;
   logic [3:0]        req_local_x = '0;
   logic [3:0]        req_local_y = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic [9:0]        rsp_face_number;
   logic [17:0]       rsp_dof_index;
   logic signed [3:0] rsp_orient_code;
   logic [2:0]        rsp_status;
   logic              psel = 1'b0;
   logic              penable = 1'b0;
   logic              pwrite = 1'b0;
   logic [1:0]        paddr = '0;
   logic [31:0]       pwdata = '0;
   logic [31:0]       prdata;
   logic              pready;

   localparam logic [1:0] ADDR_ORDER_M = 2'd0;

   typedef struct packed {
      logic [9:0]        face_number;
      logic [17:0]       dof_index;
      logic signed [3:0] orient_code;
      logic [2:0]        status;
   } answer_type;

   answer_type   expected_answers[$];
   logic [95:0]  stored_keys[MaxFaces];
   int unsigned  stored_count;
   logic [4:0]   model_order;
   int           mismatches;
   bit           stalls_on;
   logic [23:0]  pool[$];

   face_dof_numbering_table i_dut (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   initial begin
      #200ms;
      $display("face_dof_numbering_table: mismatch");
      $finish;
   end

   // gap length: mostly short, a few long
   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (!stalls_on) return 0;
      if (r < 55) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // canonical key of a face; returns 0 on a non-unique minimum
   function automatic bit canon(input logic [23:0] q[4], output logic [23:0] k[4]);
      logic [23:0] t;
      if (q[0] < q[1] && q[0] < q[2] && q[0] < q[3]) k = '{q[0], q[1], q[2], q[3]};
      else if (q[1] < q[0] && q[1] < q[2] && q[1] < q[3]) k = '{q[1], q[3], q[0], q[2]};
      else if (q[2] < q[0] && q[2] < q[1] && q[2] < q[3]) k = '{q[2], q[0], q[3], q[1]};
      else if (q[3] < q[0] && q[3] < q[1] && q[3] < q[2]) k = '{q[3], q[2], q[1], q[0]};
      else return 1'b0;
      if (k[2] < k[1]) begin
         t = k[1]; k[1] = k[2]; k[2] = t;
      end
      return 1'b1;
   endfunction

   function automatic bit lookup(input logic [95:0] key, output int unsigned id);
      for (int unsigned i = 0; i < stored_count; i++)
         if (stored_keys[i] == key) begin
            id = i;
            return 1'b1;
         end
      return 1'b0;
   endfunction

   // predicted answer for one face request, updating the table
   function automatic answer_type predict_face(input logic typ, input logic [23:0] q[4],
                                               input logic [3:0] ix, input logic [3:0] iy);
      answer_type  ans;
      logic [23:0] k[4];
      logic [95:0] key;
      int unsigned id, n, r, off;
      int          o;
      ans = '0;
      id = 0;
      o = 0;
      off = 0;
      if (!canon(q, k)) begin
         ans.status = ST_BAD;
         return ans;
      end
      key = {k[0], k[1], k[2], k[3]};
      if (typ == REQ_INSERT) begin
         if (lookup(key, id)) ans.status = ST_FOUND;
         else if (stored_count >= MaxFaces) ans.status = ST_FULL;
         else begin
            id = stored_count;
            stored_keys[id] = key;
            stored_count++;
            ans.status = ST_INSERTED;
         end
         if (ans.status < ST_ABSENT) ans.face_number = id[9:0];
         return ans;
      end
      if (model_order < 2 || model_order > 16 || ix >= model_order - 2 ||
          iy >= model_order - 2) begin
         ans.status = ST_RANGE;
         return ans;
      end
      if (!lookup(key, id)) begin
         ans.status = ST_ABSENT;
         return ans;
      end
      n = model_order - 2;
      r = n - 1;
      if (k[0] == q[0] && k[1] == q[1]) o = 1;
      else if (k[0] == q[0] && k[2] == q[1]) o = -1;
      else if (k[1] == q[0] && k[3] == q[1]) o = 2;
      else if (k[1] == q[0] && k[0] == q[1]) o = -2;
      else if (k[3] == q[0] && k[2] == q[1]) o = 3;
      else if (k[3] == q[0] && k[1] == q[1]) o = -3;
      else if (k[2] == q[0] && k[0] == q[1]) o = 4;
      else if (k[2] == q[0] && k[3] == q[1]) o = -4;
      case (o)
         1:  off = n * iy + ix;
         2:  off = n * (r - ix) + iy;
         3:  off = n * (r - iy) + (r - ix);
         4:  off = n * ix + (r - iy);
         -1: off = n * ix + iy;
         -2: off = n * iy + (r - ix);
         -3: off = n * (r - ix) + (r - iy);
         -4: off = n * (r - iy) + ix;
         default: off = 0;
      endcase
      if (o == 0) begin
         ans.status = ST_BAD;
         return ans;
      end
      ans.status = ST_FOUND;
      ans.face_number = id[9:0];
      ans.dof_index = 18'(id * n * n + off);
      ans.orient_code = 4'(o);
      return ans;
   endfunction

   // send one face request and queue its answer at the transfer
   task automatic send_face(input logic typ, input logic [23:0] a, input logic [23:0] b,
                            input logic [23:0] c, input logic [23:0] d,
                            input logic [3:0] ix, input logic [3:0] iy);
      logic [23:0] q[4];
      int          g;
      g = gap_len();
      if (g > 0) begin
         req_valid <= 1'b0;
         repeat (g) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_type <= typ;
      req_corner_a <= a;
      req_corner_b <= b;
      req_corner_c <= c;
      req_corner_d <= d;
      req_local_x <= ix;
      req_local_y <= iy;
      q = '{a, b, c, d};
      do @(posedge clock); while (!req_ready);
      expected_answers.insert(expected_answers.size(), predict_face(typ, q, ix, iy));
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (expected_answers.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic write_order(input logic [4:0] m);
      drain();
      psel <= 1'b1;
      pwrite <= 1'b1;
      paddr <= ADDR_ORDER_M;
      pwdata <= {27'd0, m};
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      model_order = m;
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   // result checker
   always @(posedge clock) begin
      answer_type got, want;
      if (!reset && rsp_valid && rsp_ready) begin
         got = {rsp_face_number, rsp_dof_index, rsp_orient_code, rsp_status};
         if (expected_answers.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %h", got);
         end else begin
            want = expected_answers.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("face %0d/%0d dof %0d/%0d orient %0d/%0d status %0d/%0d",
                           want.face_number, got.face_number, want.dof_index,
                           got.dof_index, want.orient_code, got.orient_code,
                           want.status, got.status);
            end
         end
      end
   end

   // result stalls
   always @(negedge clock) begin
      int g;
      g = gap_len();
      if (rsp_ready && stalls_on && g > 0 && $urandom_range(0, 2) == 0) begin
         rsp_ready <= 1'b0;
         repeat (g) @(negedge clock);
      end
      rsp_ready <= 1'b1;
   end

   task automatic test_directed();
      stalls_on = 1'b0;
      send_face(REQ_QUERY, 1, 2, 3, 4, 0, 0);
      send_face(REQ_INSERT, 1, 2, 3, 4, 0, 0);
      send_face(REQ_INSERT, 1, 2, 3, 4, 0, 0);
      send_face(REQ_INSERT, 5, 5, 6, 7, 0, 0);
      send_face(REQ_QUERY, 9, 9, 9, 9, 0, 0);
      send_face(REQ_INSERT, 24'hFFFFFF, 24'hFFFFFE, 24'hFFFFFD, 0, 15, 15);
      send_face(REQ_INSERT, 24'h800000, 24'h7FFFFF, 24'hAAAAAA, 24'h555555, 0, 0);
      send_face(REQ_QUERY, 1, 2, 3, 4, 1, 0);
      send_face(REQ_QUERY, 1, 2, 3, 4, 15, 15);
      // all eight orientations of face 1,2,3,4 (key 1,2,3,4)
      send_face(REQ_QUERY, 1, 2, 3, 4, 0, 0);
      send_face(REQ_QUERY, 1, 3, 2, 4, 0, 0);
      send_face(REQ_QUERY, 2, 4, 1, 3, 0, 0);
      send_face(REQ_QUERY, 2, 1, 4, 3, 0, 0);
      send_face(REQ_QUERY, 4, 3, 2, 1, 0, 0);
      send_face(REQ_QUERY, 4, 2, 3, 1, 0, 0);
      send_face(REQ_QUERY, 3, 1, 4, 2, 0, 0);
      send_face(REQ_QUERY, 3, 4, 1, 2, 0, 0);
      send_face(REQ_QUERY, 24'hFFFFFE, 0, 24'hFFFFFF, 24'hFFFFFD, 0, 0);
   endtask

   task automatic test_orders();
      logic [4:0] orders[6] = '{16, 2, 0, 31, 5, 17};
      foreach (orders[i]) begin
         write_order(orders[i]);
         send_face(REQ_QUERY, 1, 2, 3, 4, 0, 0);
         send_face(REQ_QUERY, 3, 4, 1, 2, 13, 13);
         send_face(REQ_QUERY, 2, 4, 1, 3, 2, 1);
      end
   endtask

   task automatic random_face(output logic [23:0] c[4]);
      for (int j = 0; j < 4; j++)
         c[j] = ($urandom_range(0, 3) == 0) ? 24'($urandom) : 24'($urandom_range(0, 40));
   endtask

   task automatic test_random(input int count);
      logic [23:0] c[4];
      logic [23:0] s[4];
      int          p, sel;
      stalls_on = 1'b1;
      for (int i = 0; i < count; i++) begin
         sel = $urandom_range(0, 9);
         random_face(c);
         if (sel < 6 && pool.size() >= 4) begin
            // rotate or flip a pooled face so that a query of it can hit a stored key
            p = $urandom_range(0, pool.size() / 4 - 1) * 4;
            s = '{pool[p], pool[p + 1], pool[p + 2], pool[p + 3]};
            case ($urandom_range(0, 7))
               0: c = '{s[0], s[1], s[2], s[3]};
               1: c = '{s[0], s[2], s[1], s[3]};
               2: c = '{s[1], s[3], s[0], s[2]};
               3: c = '{s[1], s[0], s[3], s[2]};
               4: c = '{s[3], s[2], s[1], s[0]};
               5: c = '{s[3], s[1], s[2], s[0]};
               6: c = '{s[2], s[0], s[3], s[1]};
               default: c = '{s[2], s[3], s[0], s[1]};
            endcase
         end else if (sel < 9) begin
            foreach (c[j]) pool.insert(pool.size(), c[j]);
         end
         send_face((sel < 9 && sel >= 6) ? REQ_INSERT : 1'($urandom_range(0, 1)),
                   c[0], c[1], c[2], c[3], 4'($urandom_range(0, 15)),
                   ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                               : 4'($urandom_range(0, 13)));
         if (i % 150 == 149) write_order(5'($urandom_range(2, 16)));
      end
   endtask

   initial begin
      mismatches = 0;
      stored_count = 0;
      model_order = 3;
      stalls_on = 1'b0;
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_directed();
      test_orders();
      write_order(6);
      test_random(544);
      drain();
      if (mismatches == 0 && expected_answers.size() == 0)
         $display("face_dof_numbering_table: match");
      else
         $display("face_dof_numbering_table: mismatch");
      $finish;
   end
endmodule
